/* src/ssdw_pkg.sv */
// ----------------------------------------------------------------------------
// ssdw_pkg
// Shared types, codes and constants for the seven-segment display writer.
// ----------------------------------------------------------------------------
package ssdw_pkg;

   typedef enum logic [2:0] {
      MODE_RAW   = 3'd0,
      MODE_HEX   = 3'd1,
      MODE_HEX16 = 3'd2,
      MODE_DEC16 = 3'd3,
      MODE_HEX8  = 3'd4,
      MODE_CLEAR = 3'd5,
      MODE_ERR   = 3'd6
   } mode_type;

   localparam logic [7:0] RAW_CTRL   = 8'h78;
   localparam logic [7:0] HEX_CTRL   = 8'h58;
   localparam logic [7:0] BLANK_SEG  = 8'h80;
   localparam logic [2:0] ADDR_MASK  = 3'h7;

   // divide by ten: q = (x * DEC_RECIP) >> DEC_SHIFT, exact for 16-bit x
   localparam logic [16:0] DEC_RECIP = 17'd52429;
   localparam int          DEC_SHIFT = 19;
   localparam int          PROD_W    = 33;
   localparam int          QUOT_W    = PROD_W - DEC_SHIFT;
   localparam logic [3:0]  DEC_BASE  = 4'd10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = QUEUE_AW + 1;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  addr;
      logic [15:0] value;
      logic        line;
      logic [3:0]  dp;
      logic [2:0]  last_step;
   } cmd_type;

   function automatic logic [7:0] err_segment(input logic [1:0] idx);
      logic [7:0] seg;
      unique case (idx)
         2'd0:    seg = 8'b1100_1111;
         2'd1:    seg = 8'b1000_1100;
         2'd2:    seg = 8'b0000_1100;
         default: seg = 8'b1000_0000;
      endcase
      return seg;
   endfunction

endpackage

/* src/ssdw_front.sv */
// ----------------------------------------------------------------------------
// ssdw_front
// Accepts display commands, sizes each burst of digit writes and drops
// unused mode codes before they reach the command queue.
// ----------------------------------------------------------------------------
module ssdw_front (
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_digit_address,
   input  logic [15:0]        req_value,
   input  logic               req_line,
   input  logic [3:0]         req_dp_mask,
   input  logic               queue_full,
   output logic               push,
   output ssdw_pkg::cmd_type  cmd
);
   import ssdw_pkg::*;

   logic       known;
   logic [2:0] last_step;

   always_comb begin
      known     = 1'b1;
      last_step = 3'd0;
      unique case (req_mode) inside
         MODE_RAW, MODE_HEX:               last_step = 3'd0;
         MODE_HEX8:                        last_step = 3'd1;
         MODE_HEX16, MODE_DEC16, MODE_ERR: last_step = 3'd3;
         MODE_CLEAR:                       last_step = 3'd7;
         default: begin
            known     = 1'b0;
            last_step = 3'd0;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && known;

   always_comb begin
      cmd.mode      = mode_type'(req_mode);
      cmd.addr      = req_digit_address;
      cmd.value     = req_value;
      cmd.line      = req_line;
      cmd.dp        = req_dp_mask;
      cmd.last_step = last_step;
   end

endmodule

/* src/ssdw_queue.sv */
// ----------------------------------------------------------------------------
// ssdw_queue
// Short command queue between the front and the write sequencer.
// ----------------------------------------------------------------------------
module ssdw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ssdw_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output ssdw_pkg::cmd_type  head_cmd
);
   import ssdw_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff,  count_in;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

/* src/ssdw_back.sv */
// ----------------------------------------------------------------------------
// ssdw_back
// Steps through the queued command one digit write per transfer and holds
// each write in the output register.
// ----------------------------------------------------------------------------
module ssdw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ssdw_pkg::cmd_type  head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_control_byte,
   output logic [7:0]         rsp_data_byte,
   output logic               rsp_last
);
   import ssdw_pkg::*;

   logic [2:0]        step_ff, step_in;
   logic [QUOT_W-1:0] work_ff, work_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        ctrl_ff, ctrl_in;
   logic [7:0]        data_ff, data_in;
   logic              last_ff, last_in;

   logic              advance;
   logic              emit;
   logic              is_last;
   logic [1:0]        sidx;
   logic [15:0]       dec_src;
   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] quot;
   logic [15:0]       dec_diff;
   logic [3:0]        dec_digit;
   logic [3:0]        nibble;
   logic              dp_on;
   logic [2:0]        waddr;
   logic              hex_write;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = head_valid && advance;
   assign is_last = (step_ff == head_cmd.last_step);
   assign pop     = emit && is_last;
   assign sidx    = step_ff[1:0];

   always_comb begin
      dec_src   = (step_ff == 3'd0) ? head_cmd.value : 16'(work_ff);
      prod      = PROD_W'(dec_src) * PROD_W'(DEC_RECIP);
      quot      = prod[PROD_W-1:DEC_SHIFT];
      dec_diff  = dec_src - 16'(16'(quot) * 16'(DEC_BASE));
      dec_digit = dec_diff[3:0];
   end

   always_comb begin
      hex_write = 1'b1;
      nibble    = '0;
      dp_on     = 1'b0;
      waddr     = head_cmd.addr;
      data_in   = BLANK_SEG;
      unique case (head_cmd.mode)
         MODE_RAW: begin
            hex_write = 1'b0;
            data_in   = head_cmd.value[7:0];
         end
         MODE_HEX: begin
            nibble = head_cmd.value[3:0];
            dp_on  = head_cmd.dp[0];
         end
         MODE_HEX16: begin
            waddr  = {head_cmd.line, ~sidx};
            nibble = head_cmd.value[{sidx, 2'b00} +: 4];
            dp_on  = head_cmd.dp[~sidx];
         end
         MODE_DEC16: begin
            waddr  = {head_cmd.line, ~sidx};
            nibble = dec_digit;
            dp_on  = head_cmd.dp[~sidx];
         end
         MODE_HEX8: begin
            waddr  = step_ff[0] ? head_cmd.addr + 3'd1 : head_cmd.addr;
            nibble = step_ff[0] ? head_cmd.value[3:0] : head_cmd.value[7:4];
         end
         MODE_CLEAR: begin
            hex_write = 1'b0;
            waddr     = step_ff;
            data_in   = BLANK_SEG;
         end
         MODE_ERR: begin
            hex_write = 1'b0;
            waddr     = {head_cmd.line, sidx};
            data_in   = err_segment(sidx);
         end
         default: begin
            hex_write = 1'b0;
         end
      endcase
      if (hex_write) begin
         data_in = {!dp_on, 3'b000, nibble};
      end
      ctrl_in = (hex_write ? HEX_CTRL : RAW_CTRL) | {5'b00000, waddr & ADDR_MASK};
      last_in = is_last;
   end

   always_comb begin
      step_in      = step_ff;
      work_in      = work_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      if (emit) begin
         step_in      = is_last ? 3'd0 : step_ff + 3'd1;
         work_in      = quot;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         ctrl_ff <= ctrl_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_control_byte = ctrl_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_last         = last_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> step_ff <= head_cmd.last_step)
      else $error("step past end of command");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> step_ff == 3'd0)
      else $error("step not cleared while idle");

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (head_valid && head_cmd.mode == MODE_DEC16) |-> dec_diff < 16'(DEC_BASE))
      else $error("decimal digit out of range");

endmodule

/* src/seven_segment_display_writer.sv */
// ----------------------------------------------------------------------------
// seven_segment_display_writer
// Turns display commands into bursts of control/data byte writes for an
// eight-digit seven-segment driver chip.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    mode, digit_address, value, line,
//                                         dp_mask
//  rsp      out        rsp_valid/stall    control_byte, data_byte, last
//
// One digit write leaves per cycle while rsp is not stalled; a command makes
// one to eight writes (raw and hex digit 1, hex8 2, hex16, decimal16 and Err
// 4, clear 8); the write sequencer emits one write per output transfer.
// A two-entry command queue lets commands enter while a burst is still out.
// Decimal digits come one per unstalled cycle via a reciprocal divide by 10.
// Reset is synchronous and clears the queue, the step counter and rsp_valid.
// A stall on rsp holds the output register and, once the queue fills, req.
// ----------------------------------------------------------------------------
module seven_segment_display_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [2:0]  req_digit_address,
   input  logic [15:0] req_value,
   input  logic        req_line,
   input  logic [3:0]  req_dp_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_control_byte,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last
);
   import ssdw_pkg::*;

   logic    queue_full;
   logic    push;
   logic    pop;
   logic    head_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   ssdw_front u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_digit_address (req_digit_address),
      .req_value         (req_value),
      .req_line          (req_line),
      .req_dp_mask       (req_dp_mask),
      .queue_full        (queue_full),
      .push              (push),
      .cmd               (push_cmd)
   );

   ssdw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ssdw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_control_byte (rsp_control_byte),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last         (rsp_last)
   );

endmodule
